// File: hw/rtl/sha256_message_digest_unit_assert.svh
// Assertion macros shared by the digest unit checker.
// Included by bare file name; no other dependencies.
`ifndef SHA256_MESSAGE_DIGEST_UNIT_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: hw/rtl/sha_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and round functions of the SHA-256 digest unit.
// No dependencies.
package sha_pkg;
  localparam int WordWidth = 32;
  localparam int CountWidth = 61;
  localparam int Rounds = 64;
  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [WordWidth-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_EMIT
  } state_t;

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic  load;       // copy chaining words into working words
    logic  round;      // run one round
    logic  add;        // fold working words into chaining words
    logic  init;       // return chaining words to initial values
    logic  wr_byte;    // write one byte into the schedule window
    logic [5:0] pos;   // byte position for wr_byte
    logic [7:0] data;  // byte for wr_byte
    logic [5:0] rnd;   // round index
  } ctrl_t;

  function automatic word_t init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6a09e667;
      3'd1: init_hash = 32'hbb67ae85;
      3'd2: init_hash = 32'h3c6ef372;
      3'd3: init_hash = 32'ha54ff53a;
      3'd4: init_hash = 32'h510e527f;
      3'd5: init_hash = 32'h9b05688c;
      3'd6: init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,32'h923f82a4,
    32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,32'h72be5d74,32'h80deb1fe,
    32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,
    32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
    32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,
    32'h53380d13,32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,32'h19a4c116,
    32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
    32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,32'h90befffa,32'ha4506ceb,32'hbef9a3f7,
    32'hc67178f2};

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (WordWidth - n));
  endfunction
endpackage

// File: hw/rtl/sha_round_unit.sv
`timescale 1ns / 1ps
// One shared SHA-256 round: schedule window, working and chaining words.
// Depends on sha_pkg.
module sha_round_unit import sha_pkg::*; (
  input  logic   clk,
  input  ctrl_t  ctrl,
  input  logic [2:0] rd_sel,
  output word_t  rd_word
);
  word_t win [16];
  word_t v [8];
  word_t h [8];
  logic [3:0] slot;
  word_t wa, wb, s0, s1, w, t1, t2;

  always_comb begin
    slot = ctrl.rnd[3:0];
    wa = win[slot + 4'd14];
    wb = win[slot + 4'd1];
    s1 = rotr(wa, 17) ^ rotr(wa, 19) ^ (wa >> 10);
    s0 = rotr(wb, 7) ^ rotr(wb, 18) ^ (wb >> 3);
    w = (ctrl.rnd[5:4] == 2'd0) ? win[slot] : s1 + win[slot + 4'd9] + s0 + win[slot];
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[ctrl.rnd] + w;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
    rd_word = h[rd_sel];
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_byte) begin
      case (ctrl.pos[1:0])
        2'd0: win[ctrl.pos[5:2]][31:24] <= ctrl.data;
        2'd1: win[ctrl.pos[5:2]][23:16] <= ctrl.data;
        2'd2: win[ctrl.pos[5:2]][15:8] <= ctrl.data;
        default: win[ctrl.pos[5:2]][7:0] <= ctrl.data;
      endcase
    end
    if (ctrl.round) begin
      win[slot] <= w;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
    if (ctrl.load) v <= h;
    for (int i = 0; i < 8; i++) begin
      if (ctrl.init) h[i] <= init_hash(3'(i));
      else if (ctrl.add) h[i] <= h[i] + v[i];
    end
  end
endmodule

// File: hw/rtl/sha_sequencer.sv
`timescale 1ns / 1ps
// Sequencer: byte intake, padding, round count and digest emission.
// Depends on sha_pkg.
module sha_sequencer import sha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       last_word,
  output ctrl_t      ctrl,
  output logic [2:0] rd_sel
);
  state_t state, state_next;
  logic [CountWidth-1:0] count, count_next;
  logic [5:0] rnd, rnd_next;
  logic [5:0] ppos, ppos_next;
  logic       fin, fin_next;
  logic       pad, pad_next;
  logic       len_here, len_here_next;
  logic [2:0] wsel, wsel_next;
  logic [63:0] bits;
  logic [2:0] lb;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; count <= '0; rnd <= '0; ppos <= '0; fin <= 1'b0; wsel <= '0;
      pad <= 1'b0; len_here <= 1'b0;
    end else begin
      state <= state_next; count <= count_next; rnd <= rnd_next;
      ppos <= ppos_next; fin <= fin_next; wsel <= wsel_next;
      pad <= pad_next; len_here <= len_here_next;
    end
  end

  always_comb begin
    state_next = state; count_next = count; rnd_next = rnd;
    ppos_next = ppos; fin_next = fin; wsel_next = wsel;
    pad_next = pad; len_here_next = len_here;
    ctrl = '0;
    ctrl.rnd = rnd;
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_EMIT);
    last_word = (wsel == 3'd7);
    rd_sel = wsel;
    bits = {count, 3'b000};
    lb = 3'd7 - ppos[2:0];
    case (state)
      ST_IDLE: begin
        ctrl.pos = count[5:0];
        ctrl.data = data_byte;
        if (in_valid) begin
          ctrl.wr_byte = 1'b1;
          count_next = count + 1'b1;
          fin_next = final_byte;
          pad_next = final_byte;
          len_here_next = 1'b0;
          ppos_next = count[5:0] + 6'd1;
          if (count[5:0] == 6'd63) state_next = ST_LOAD;
          else if (final_byte) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        // first pad byte is 0x80, then zeros; the length fills bytes 56..63
        // of the block that still has room for it after the 0x80
        ctrl.wr_byte = 1'b1;
        ctrl.pos = ppos;
        if (fin) begin
          ctrl.data = PadByte;
          len_here_next = (ppos <= 6'd55);
        end else if (len_here && ppos >= 6'd56) ctrl.data = bits[8*lb +: 8];
        else ctrl.data = 8'h00;
        fin_next = 1'b0;
        ppos_next = ppos + 6'd1;
        if (ppos == 6'd63) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        ctrl.load = 1'b1;
        rnd_next = '0;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        ctrl.round = 1'b1;
        rnd_next = rnd + 6'd1;
        if (rnd == 6'(Rounds - 1)) state_next = ST_ADD;
      end
      ST_ADD: begin
        ctrl.add = 1'b1;
        // final byte closed the block: pad a fresh block; length block done:
        // emit; 0x80 spilled past byte 55: one more block carries the length
        if (fin) state_next = ST_PAD;
        else if (pad && len_here) state_next = ST_EMIT;
        else if (pad) begin
          len_here_next = 1'b1;
          state_next = ST_PAD;
        end
        else state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_ready) begin
          wsel_next = wsel + 3'd1;
          if (wsel == 3'd7) begin
            ctrl.init = 1'b1;
            count_next = '0;
            pad_next = 1'b0;
            len_here_next = 1'b0;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// File: hw/rtl/sha256_message_digest_unit.sv
`timescale 1ns / 1ps
// SHA-256 message digest unit, fed one byte per transfer.
// Depends on sha_pkg, sha_sequencer, sha_round_unit.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------
//  input    | in_valid / in_ready   | data_byte, final_byte
//  output   | out_valid / out_ready | digest_word, last_word
//
// A byte that does not close a 64-byte block leaves the sequencer idle. A
// block-closing byte is followed by load, rounds and fold in the single shared
// round unit. A final byte adds padding at one byte per cycle, one or two
// more compressions, then eight output transfers. in_ready is low meanwhile.
// rst is synchronous; it drops any message in progress and reloads the
// chaining words, so the first message after reset starts from the initial values.
module sha256_message_digest_unit import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic        last_word
);
  ctrl_t ctrl, ctrl_q;
  logic [2:0] rd_sel;
  logic rst_q;

  // Hold reset into the datapath so the chaining words reload on reset.
  always_ff @(posedge clk) rst_q <= rst;

  always_comb begin
    ctrl_q = ctrl;
    if (rst || rst_q) ctrl_q.init = 1'b1;
  end

  sha_sequencer u_seq (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .final_byte,
    .out_valid, .out_ready, .last_word, .ctrl, .rd_sel
  );

  sha_round_unit u_round (
    .clk, .ctrl(ctrl_q), .rd_sel, .rd_word(digest_word)
  );
endmodule

// File: hw/rtl/sha_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the digest unit, bound to the top level.
// Depends on sha256_message_digest_unit_assert.svh.
`include "sha256_message_digest_unit_assert.svh"
module sha_checker (
  input logic clk, rst, in_valid, in_ready, out_valid, out_ready, last_word
);
  `SHA_ASSERT_IMPL(a_no_both, clk, rst, out_valid, !in_ready, "accept during output")
  `SHA_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid, "output dropped")
  `SHA_ASSERT_NEXT(a_last_end, clk, rst, out_valid && out_ready && last_word, !out_valid,
    "output after last word")
endmodule

bind sha256_message_digest_unit sha_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .last_word
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the SHA-256 message digest unit: byte stream in,
// eight digest words out. Depends on sha_pkg and sha256_message_digest_unit.
module testbench;
  import sha_pkg::*;

  localparam int unsigned StallLimit = 20000;

  // Expected digest words of finished messages, oldest first.
  class digest_scoreboard;
    logic [31:0] pending_words[$];
    logic        pending_last[$];
    logic [31:0] hash_state[8];
    logic [31:0] block_words[16];
    logic [63:0] msg_bytes;
    int          mismatch_count;
    int          digests_done;

    function void restart();
      for (int i = 0; i < 8; i++) hash_state[i] = init_hash(i[2:0]);
      msg_bytes = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 rounds over the filled block and fold into the hash state.
    function void compress();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      for (int i = 0; i < 16; i++) w[i] = block_words[i];
      for (int i = 16; i < 64; i++)
        w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
             + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endfunction

    function int place(int pos, logic [7:0] b);
      block_words[pos / 4][31 - 8 * (pos % 4) -: 8] = b;
      pos = (pos + 1) % 64;
      if (pos == 0) compress();
      return pos;
    endfunction

    // Note one accepted byte; on a final byte pad and queue the digest.
    function void note_byte(logic [7:0] b, logic fin);
      int pos;
      logic [63:0] bits;
      pos = place(int'(msg_bytes[5:0]), b);
      msg_bytes = (msg_bytes + 1) & 64'h1FFF_FFFF_FFFF_FFFF;
      if (!fin) return;
      bits = msg_bytes << 3;
      pos = place(pos, PadByte);
      while (pos != 56) pos = place(pos, 8'h00);
      for (int i = 7; i >= 0; i--) pos = place(pos, bits[8*i +: 8]);
      for (int i = 0; i < 8; i++) begin
        pending_words = {pending_words, hash_state[i]};
        pending_last = {pending_last, (i == 7)};
      end
      restart();
    endfunction

    function void report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
    endfunction

    function void check_word(logic [31:0] word, logic last);
      logic [31:0] exp_word;
      logic        exp_last;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected digest word %h", word));
        return;
      end
      exp_word = pending_words.pop_front();
      exp_last = pending_last.pop_front();
      if (word !== exp_word)
        report($sformatf("digest_word %h, expected %h", word, exp_word));
      if (last !== exp_last)
        report($sformatf("last_word %b, expected %b", last, exp_last));
      if (exp_last) digests_done++;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        final_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic        last_word;

  digest_scoreboard board = new();
  int unsigned idle_cycles = 0;
  int          bytes_sent = 0;
  bit          stall_mode = 0;

  always #6 clk = ~clk;

  sha256_message_digest_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .final_byte(final_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .last_word(last_word)
  );

  // Sample both channels at the rising edge; the scoreboard sees each
  // transfer exactly once. Count cycles with no transfer for the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) board.note_byte(data_byte, final_byte);
      if (out_valid && out_ready) board.check_word(digest_word, last_word);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no transfer for %0d cycles", StallLimit);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Receiver: stall on its own pattern, with open stretches in between.
  always @(negedge clk) begin
    if ($urandom_range(0, 99) < 3) stall_mode = ~stall_mode;
    if (rst) out_ready <= 1'b0;
    else if (stall_mode) out_ready <= ($urandom_range(0, 3) == 0);
    else out_ready <= 1'b1;
  end

  // Hold one byte on the input until it transfers; valid stays up so the
  // next byte can follow at once, and the caller drops it for a gap.
  task automatic send_byte(logic [7:0] b, logic fin);
    in_valid <= 1'b1;
    data_byte <= b;
    final_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send a whole message in bursts of random length with random gaps.
  task automatic send_message(int len, bit random_data);
    int burst;
    burst = $urandom_range(1, 40);
    for (int i = 0; i < len; i++) begin
      send_byte(random_data ? 8'($urandom) : 8'(i), i == len - 1);
      if (--burst == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        burst = $urandom_range(1, 40);
      end
    end
  endtask

  initial begin
    board.restart();
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Directed: one-byte messages at the byte extremes, a three-byte message,
    // then the padding boundaries: 63 bytes puts 0x80 last and spills the length
    // into an extra block, 64 bytes ends the message on a full block.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_message(3, 0);
    send_message(63, 1);
    send_message(64, 1);
    // Random short messages.
    while (bytes_sent < 150) send_message($urandom_range(1, 20), 1);
    in_valid <= 1'b0;
    while (board.pending_words.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("sent %0d bytes, checked %0d digests including padding boundaries",
             bytes_sent, board.digests_done);
    if (board.mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
